### hdl/assert_macros.svh
// Assertion macros for the projector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/rsp_pkg.sv
// Shared widths, register indexes, types and helper functions of the road projector.
`default_nettype none

package rsp_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_DEPTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_HALF_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH    = 3'd5;

  // Stream widths.
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 3;

  // Serial divider: Q16 scale = (camera_depth << 16) / distance.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 26;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Shared multiplier operands and product.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Projected values are clamped to +-2^33; beyond that the pixel result saturates anyway.
  localparam logic signed [PROD_W-1:0] PROJ_LIM_HI = 63'sd8589934592;
  localparam logic signed [PROD_W-1:0] PROJ_LIM_LO = -63'sd8589934592;
  localparam logic signed [MUL_A_W-1:0] HALF_SCREEN_Q17 = 35'sd65536;
  localparam int FRAC_SHIFT = 17;

  localparam logic signed [PROD_W-1:0] PIX_HI = 63'sd32767;
  localparam logic signed [PROD_W-1:0] PIX_LO = -63'sd32768;

  localparam logic signed [32:0] CRV_HI = 33'sd2147483647;
  localparam logic signed [32:0] CRV_LO = -33'sd2147483648;

  // Division by three for the stripe: ceil(2^17 / 3) is exact for 16-bit indexes.
  localparam logic [32:0] STRIPE_RECIP = 33'd43691;
  localparam int STRIPE_SHIFT = 17;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a raw product to the projection limits.
  function automatic logic signed [MUL_A_W-1:0] clamp_proj(input logic signed [PROD_W-1:0] p);
    logic signed [MUL_A_W-1:0] r;
    if (p > PROJ_LIM_HI) begin
      r = PROJ_LIM_HI[MUL_A_W-1:0];
    end else if (p < PROJ_LIM_LO) begin
      r = PROJ_LIM_LO[MUL_A_W-1:0];
    end else begin
      r = p[MUL_A_W-1:0];
    end
    return r;
  endfunction

  // Floor-divide by 2^17 and saturate to a 16-bit pixel value.
  function automatic logic signed [15:0] to_pixel(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [15:0] r;
    s = p >>> FRAC_SHIFT;
    if (s > PIX_HI) begin
      r = 16'sh7fff;
    end else if (s < PIX_LO) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

  // Saturate a curve sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat_curve(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > CRV_HI) begin
      r = 32'sh7fffffff;
    end else if (v < CRV_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rsp_div.sv
// Restoring serial divider, one quotient bit per cycle, for the perspective scale.
`default_nettype none

module rsp_div
  import rsp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;
  logic                  fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !trial[DIVISOR_W+1];

  // Step counter and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register; the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### hdl/road_segment_projector_top.sv
// Top level of the pseudo-3D road segment projector.
//
//  Channel   Direction  Fields
//  s_axis    in         tuser: frame_start; tdata: segment and camera fields
//  m_axis    out        tuser: visible, behind_camera, stripe; tdata: pixel fields
//  cfg       in         write enable, register index, data; no read-back
//
// From input transfer to the next input transfer, a segment runs through a setup
// step, the 32-step serial divider, then six passes through the shared
// multiplier, each followed by a clamp or saturate step, and an output step.
// A segment behind the camera skips the divider.
// The input is ready only when the sequencer is idle; a finished result waits
// in the output register, and the sequencer holds before its last step while it
// is still occupied. Reset clears the curve, horizon and previous-segment state.
`default_nettype none

`include "assert_macros.svh"

module road_segment_projector_top
  import rsp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // cam_pos[23:0], cam_lateral[44:24], base_height[61:45], seg_z[85:62],
  // seg_x[102:86], seg_y[119:103], seg_curve[135:120], wrapped[136],
  // seg_index[152:137], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // frame_start
  input  wire logic                  s_axis_tuser_i,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // screen_x[15:0], screen_y[31:16], half_width_px[47:32], clip_y[63:48],
  // prev_x[79:64], prev_y[95:80], prev_w[111:96]
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // visible[0], behind_camera[1], stripe[2]
  output      logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_DIV,
    ST_MX1, ST_FX1, ST_MX2, ST_FX2,
    ST_MY1, ST_FY1, ST_MY2, ST_FY2,
    ST_MW1, ST_FW1, ST_MW2, ST_FW2,
    ST_OUT
  } state_e;

  // Configuration registers.
  logic [15:0] cam_depth_q, cam_height_q, road_hw_q;
  logic [11:0] scr_w_q, scr_h_q;
  logic [23:0] track_len_q;

  // Control and frame state.
  state_e             state_q;
  logic               m_valid_q;
  logic signed [31:0] curve_off_q, curve_step_q;
  logic signed [15:0] horizon_q, last_x_q, last_y_q, last_w_q;

  // Latched input item.
  logic [23:0]        in_cam_pos_q, in_seg_z_q;
  logic signed [20:0] in_lat_q;
  logic signed [16:0] in_base_q, in_seg_x_q, in_seg_y_q;
  logic signed [15:0] in_curve_q;
  logic               in_wrapped_q;
  logic [15:0]        in_idx_q;

  // Datapath registers.
  logic signed [MUL_B_W-1:0] dx_q, dy_q;
  logic [DIVIDEND_W-1:0]     scale_q;
  logic signed [MUL_A_W-1:0] acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [15:0]        sx_q, sy_q, hw_q;
  logic                      behind_q, stripe_q;

  // Output register.
  logic signed [15:0] o_sx_q, o_sy_q, o_hw_q, o_clip_q, o_px_q, o_py_q, o_pw_q;
  logic               o_vis_q, o_behind_q, o_stripe_q;

  logic               in_xfer, out_load, vis;
  logic signed [26:0] depth_dist;
  logic               behind;
  logic signed [33:0] cx_num;
  logic signed [25:0] camx;
  logic signed [18:0] camy;
  logic signed [MUL_B_W-1:0] dx, dy;
  logic [32:0]        stripe_prod;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);
  assign vis      = !behind_q && (sy_q <= horizon_q);

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_depth_q  <= 16'd100;
      cam_height_q <= 16'd1500;
      road_hw_q    <= 16'd1000;
      scr_w_q      <= 12'd640;
      scr_h_q      <= 12'd480;
      track_len_q  <= 24'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAMERA_DEPTH:    cam_depth_q  <= cfg_data_i[15:0];
        REG_CAMERA_HEIGHT:   cam_height_q <= cfg_data_i[15:0];
        REG_ROAD_HALF_WIDTH: road_hw_q    <= cfg_data_i[15:0];
        REG_SCREEN_WIDTH:    scr_w_q      <= cfg_data_i[11:0];
        REG_SCREEN_HEIGHT:   scr_h_q      <= cfg_data_i[11:0];
        REG_TRACK_LENGTH:    track_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Depth distance, wrapped past the track end when flagged.
  assign depth_dist = $signed({3'b000, in_seg_z_q}) - $signed({3'b000, in_cam_pos_q})
                    + $signed({3'b000, in_wrapped_q ? track_len_q : 24'd0});
  assign behind = depth_dist[26] || (depth_dist == 27'sd0);

  // Camera x with the curve offset, divided by 256 and truncated toward zero.
  assign cx_num = $signed({{5{in_lat_q[20]}}, in_lat_q, 8'h00})
                - $signed({{2{curve_off_q[31]}}, curve_off_q});
  assign camx = $signed(cx_num[33:8])
              + $signed({25'd0, cx_num[33] && (cx_num[7:0] != 8'h00)});
  assign camy = $signed({3'b000, cam_height_q}) + $signed({{2{in_base_q[16]}}, in_base_q});

  assign dx = $signed({{11{in_seg_x_q[16]}}, in_seg_x_q}) - $signed({{2{camx[25]}}, camx});
  assign dy = $signed({{11{in_seg_y_q[16]}}, in_seg_y_q}) - $signed({{9{camy[18]}}, camy});

  // Stripe bit: bit 0 of index / 3 via a reciprocal multiply.
  assign stripe_prod = 33'(in_idx_q) * STRIPE_RECIP;

  // Divider request: issued from the setup step when the segment is ahead.
  assign div_req.start    = (state_q == ST_SETUP) && !behind;
  assign div_req.dividend = {cam_depth_q, 16'h0000};
  assign div_req.divisor  = depth_dist[DIVISOR_W-1:0];

  rsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MX1: begin
        mul_a = $signed({3'b000, scale_q});
        mul_b = dx_q;
      end
      ST_MY1: begin
        mul_a = $signed({3'b000, scale_q});
        mul_b = dy_q;
      end
      ST_MW1: begin
        mul_a = $signed({3'b000, scale_q});
        mul_b = $signed({12'd0, road_hw_q});
      end
      ST_MX2, ST_MW2: begin
        mul_a = acc_q;
        mul_b = $signed({16'd0, scr_w_q});
      end
      ST_MY2: begin
        mul_a = acc_q;
        mul_b = $signed({16'd0, scr_h_q});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Sequencer, output valid and per-frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_valid_q    <= 1'b0;
      curve_off_q  <= '0;
      curve_step_q <= '0;
      horizon_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_w_q     <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser_i) begin
              curve_off_q  <= '0;
              curve_step_q <= '0;
              horizon_q    <= $signed({4'h0, scr_h_q});
            end
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: state_q <= behind ? ST_MX1 : ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_MX1;
          end
        end
        ST_MX1: state_q <= ST_FX1;
        ST_FX1: state_q <= ST_MX2;
        ST_MX2: state_q <= ST_FX2;
        ST_FX2: state_q <= ST_MY1;
        ST_MY1: state_q <= ST_FY1;
        ST_FY1: state_q <= ST_MY2;
        ST_MY2: state_q <= ST_FY2;
        ST_FY2: state_q <= ST_MW1;
        ST_MW1: state_q <= ST_FW1;
        ST_FW1: state_q <= ST_MW2;
        ST_MW2: state_q <= ST_FW2;
        ST_FW2: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            curve_off_q  <= sat_curve(33'(curve_off_q) + 33'(curve_step_q));
            curve_step_q <= sat_curve(33'(curve_step_q) + 33'(in_curve_q));
            if (vis) begin
              horizon_q <= sy_q;
            end
            last_x_q <= sx_q;
            last_y_q <= sy_q;
            last_w_q <= hw_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Input latch and arithmetic datapath.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_cam_pos_q <= s_axis_tdata_i[23:0];
      in_lat_q     <= s_axis_tdata_i[44:24];
      in_base_q    <= s_axis_tdata_i[61:45];
      in_seg_z_q   <= s_axis_tdata_i[85:62];
      in_seg_x_q   <= s_axis_tdata_i[102:86];
      in_seg_y_q   <= s_axis_tdata_i[119:103];
      in_curve_q   <= s_axis_tdata_i[135:120];
      in_wrapped_q <= s_axis_tdata_i[136];
      in_idx_q     <= s_axis_tdata_i[152:137];
    end
    unique case (state_q)
      ST_SETUP: begin
        dx_q     <= dx;
        dy_q     <= dy;
        behind_q <= behind;
        stripe_q <= stripe_prod[STRIPE_SHIFT];
        scale_q  <= '0;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          scale_q <= div_rsp.quotient;
        end
      end
      ST_MX1, ST_MX2, ST_MY1, ST_MY2, ST_MW1, ST_MW2: prod_q <= prod_d;
      ST_FX1: acc_q <= HALF_SCREEN_Q17 + clamp_proj(prod_q);
      ST_FY1: acc_q <= HALF_SCREEN_Q17 - clamp_proj(prod_q);
      ST_FW1: acc_q <= clamp_proj(prod_q);
      ST_FX2: sx_q <= to_pixel(prod_q);
      ST_FY2: sy_q <= to_pixel(prod_q);
      ST_FW2: hw_q <= to_pixel(prod_q);
      ST_OUT: begin
        if (out_load) begin
          o_sx_q     <= sx_q;
          o_sy_q     <= sy_q;
          o_hw_q     <= hw_q;
          o_clip_q   <= horizon_q;
          o_px_q     <= last_x_q;
          o_py_q     <= last_y_q;
          o_pw_q     <= last_w_q;
          o_vis_q    <= vis;
          o_behind_q <= behind_q;
          o_stripe_q <= stripe_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {o_pw_q, o_py_q, o_px_q, o_clip_q, o_hw_q, o_sy_q, o_sx_q};
  assign m_axis_tuser_o  = {o_stripe_q, o_behind_q, o_vis_q};

  // The sequencer goes busy straight after taking a segment.
  `ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !s_axis_tready_o)
  // The divider only runs while the sequencer waits for it.
  `ASSERT_IMPL(a_div_in_div_state, clk_i, rst_ni, div_rsp.busy, state_q == ST_DIV)
  // A drawn segment is never behind the camera.
  `ASSERT_IMPL(a_vis_not_behind, clk_i, rst_ni, m_valid_q, !(o_vis_q && o_behind_q))
  // A drawn segment lies on or above the horizon it was clipped against.
  `ASSERT_IMPL(a_vis_above_clip, clk_i, rst_ni, m_valid_q && o_vis_q, o_sy_q <= o_clip_q)

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the road segment projector: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
  import rsp_pkg::*;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int     N_PHASES     = 10;
  localparam int     RANDOM_ITEMS = 920;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam longint PROJ_CLAMP   = 64'sd1099511627776;
  localparam longint CURVE_MAX    = 64'sd2147483647;
  localparam longint CURVE_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic               frame_start;
    logic [23:0]        cam_pos;
    logic signed [20:0] cam_lateral;
    logic signed [16:0] base_height;
    logic [23:0]        seg_z;
    logic signed [16:0] seg_x;
    logic signed [16:0] seg_y;
    logic signed [15:0] seg_curve;
    logic               wrapped;
    logic [15:0]        seg_index;
  } segment_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] half_width_px;
    logic signed [15:0] clip_y;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] prev_w;
    logic               visible;
    logic               behind_camera;
    logic               stripe;
  } projection_t;

  typedef enum logic {ROW_REG, ROW_SEG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    segment_t               seg;
    bit                     typed;
    projection_t            want;
  } stim_row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Register copies, at their reset values.
  logic [15:0] cam_depth = 16'd100;
  logic [15:0] cam_height = 16'd1500;
  logic [15:0] road_hw = 16'd1000;
  logic [11:0] scr_w = 12'd640;
  logic [11:0] scr_h = 12'd480;
  logic [23:0] trk_len = 24'd0;

  // Projection state carried from segment to segment.
  longint             curve_ofs = 0;
  longint             curve_stp = 0;
  logic signed [15:0] horizon = '0;
  logic signed [15:0] last_x = '0;
  logic signed [15:0] last_y = '0;
  logic signed [15:0] last_w = '0;

  projection_t pending_proj[$];
  stim_row_t   dir_rows[$];

  int n_errors = 0;
  int n_sent = 0;
  int n_frames = 0;
  int n_settings = 0;
  int n_visible = 0;
  int n_behind = 0;
  int cycles = 0;
  int burst_left = 0;
  int no_gap_left = 0;
  bit hold_req = 1'b0;

  road_segment_projector_top dut (.*);

  // Clock.
  always #2 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint limit(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    return 16'(limit(v, -64'sd32768, 64'sd32767));
  endfunction

  // Perspective projection of one segment; advances curve, horizon and previous values.
  function automatic projection_t project_segment(segment_t s);
    longint             depth_dist, scale, camx, camy, px, py, pw;
    logic signed [15:0] sx, sy, hw;
    logic [15:0]        idx3;
    bit                 behind, vis;
    projection_t        p;
    if (s.frame_start) begin
      curve_ofs = 0;
      curve_stp = 0;
      horizon = {4'd0, scr_h};
    end
    depth_dist = longint'(s.seg_z) - longint'(s.cam_pos);
    if (s.wrapped) begin
      depth_dist = depth_dist + longint'(trk_len);
    end
    behind = (depth_dist <= 0);
    scale = behind ? 64'sd0 : (longint'(cam_depth) * 64'sd65536) / depth_dist;
    camx = (longint'($signed(s.cam_lateral)) * 64'sd256 - curve_ofs) / 64'sd256;
    camy = longint'(cam_height) + longint'($signed(s.base_height));
    px = limit(scale * (longint'($signed(s.seg_x)) - camx), -PROJ_CLAMP, PROJ_CLAMP);
    py = limit(scale * (longint'($signed(s.seg_y)) - camy), -PROJ_CLAMP, PROJ_CLAMP);
    pw = limit(scale * longint'(road_hw), -PROJ_CLAMP, PROJ_CLAMP);
    sx = sat16(floor_div((64'sd65536 + px) * longint'(scr_w), 64'sd131072));
    sy = sat16(floor_div((64'sd65536 - py) * longint'(scr_h), 64'sd131072));
    hw = sat16(floor_div(pw * longint'(scr_w), 64'sd131072));
    curve_ofs = limit(curve_ofs + curve_stp, CURVE_MIN, CURVE_MAX);
    curve_stp = limit(curve_stp + longint'($signed(s.seg_curve)), CURVE_MIN, CURVE_MAX);
    p.clip_y = horizon;
    vis = !behind && (sy <= horizon);
    if (vis) begin
      horizon = sy;
    end
    idx3 = s.seg_index / 16'd3;
    p.screen_x = sx;
    p.screen_y = sy;
    p.half_width_px = hw;
    p.prev_x = last_x;
    p.prev_y = last_y;
    p.prev_w = last_w;
    p.visible = vis;
    p.behind_camera = behind;
    p.stripe = idx3[0];
    last_x = sx;
    last_y = sy;
    last_w = hw;
    return p;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_segment(segment_t s);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[152:0] = {s.seg_index, s.wrapped, s.seg_curve, s.seg_y, s.seg_x, s.seg_z,
                s.base_height, s.cam_lateral, s.cam_pos};
    return d;
  endfunction

  function automatic segment_t mk_seg(bit fs, int pos, int lat, int base, int z, int x,
                                      int y, int crv, bit wr, int idx);
    segment_t s;
    s.frame_start = fs;
    s.cam_pos = 24'(pos);
    s.cam_lateral = 21'(lat);
    s.base_height = 17'(base);
    s.seg_z = 24'(z);
    s.seg_x = 17'(x);
    s.seg_y = 17'(y);
    s.seg_curve = 16'(crv);
    s.wrapped = wr;
    s.seg_index = 16'(idx);
    return s;
  endfunction

  function automatic stim_row_t seg_row(bit fs, int pos, int lat, int base, int z, int x,
                                        int y, int crv, bit wr, int idx);
    stim_row_t r;
    r.kind = ROW_SEG;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.seg = mk_seg(fs, pos, lat, base, z, x, y, crv, wr, idx);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // A row whose result is written out by hand.
  function automatic stim_row_t typed_row(stim_row_t r, int sx, int sy, int hw, int clip,
                                          int px, int py, int pw, bit vis, bit beh, bit str);
    stim_row_t t;
    t = r;
    t.typed = 1'b1;
    t.want = '{16'(sx), 16'(sy), 16'(hw), 16'(clip), 16'(px), 16'(py), 16'(pw),
               vis, beh, str};
    return t;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    r.seg = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(stim_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Offer one segment and wait for its transfer; the expectation is queued on acceptance.
  task automatic drive_segment(segment_t s, bit typed, projection_t want);
    projection_t p;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= pack_segment(s);
    s_axis_tuser_i <= s.frame_start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    p = project_segment(s);
    pending_proj = {pending_proj, (typed ? want : p)};
    n_sent++;
    if (s.frame_start) begin
      n_frames++;
    end
  endtask

  // Sender bursts with random gaps, now and then a long stretch without any.
  task automatic after_transfer();
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) begin
        no_gap_left = 60;
      end
      s_axis_tvalid_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every projection has come back.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_CAMERA_DEPTH:    cam_depth = val[15:0];
      REG_CAMERA_HEIGHT:   cam_height = val[15:0];
      REG_ROAD_HALF_WIDTH: road_hw = val[15:0];
      REG_SCREEN_WIDTH:    scr_w = val[11:0];
      REG_SCREEN_HEIGHT:   scr_h = val[11:0];
      REG_TRACK_LENGTH:    trk_len = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Register settings of one random phase: defaults, extremes or random values.
  task automatic apply_phase_settings(int ph);
    logic [CFG_DATA_W-1:0] v [6];
    case (ph)
      0: v = '{24'd100, 24'd1500, 24'd1000, 24'd640, 24'd480, 24'd0};
      3: v = '{24'hFFFF, 24'hFFFF, 24'hFFFF, 24'hFFF, 24'hFFF, 24'hFFFFFF};
      6: v = '{24'd1, 24'd0, 24'd0, 24'd1, 24'd1, 24'd0};
      8: v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      default: begin
        v[0] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(60, 400))
                                           : 24'($urandom_range(1, 65535));
        v[1] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(500, 3000))
                                           : 24'($urandom_range(0, 65535));
        v[2] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(200, 2000))
                                           : 24'($urandom_range(0, 65535));
        v[3] = 24'($urandom_range(1, 4095));
        v[4] = 24'($urandom_range(1, 4095));
        v[5] = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(1000, 24'hFFFFFF));
      end
    endcase
    write_reg(REG_CAMERA_DEPTH, v[0]);
    write_reg(REG_CAMERA_HEIGHT, v[1]);
    write_reg(REG_ROAD_HALF_WIDTH, v[2]);
    write_reg(REG_SCREEN_WIDTH, v[3]);
    write_reg(REG_SCREEN_HEIGHT, v[4]);
    write_reg(REG_TRACK_LENGTH, v[5]);
    if (ph % 2 == 1) begin
      write_reg((ph % 4 == 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // A frame of segments, nearest first, with hills, bends and track wrap; a few are broken.
  task automatic send_frame(int nseg);
    segment_t s;
    int       len, off, x_acc, y_acc, bend, idx0;
    longint   z;
    s.cam_pos = 24'($urandom);
    s.cam_lateral = 21'($urandom_range(0, 8191) - 4096);
    s.base_height = 17'($urandom_range(0, 4000) - 2000);
    len = $urandom_range(1, 600);
    off = $urandom_range(0, len);
    x_acc = $urandom_range(0, 6000) - 3000;
    y_acc = $urandom_range(0, 2000) - 1000;
    bend = 0;
    idx0 = $urandom_range(0, 65535);
    for (int i = 0; i < nseg; i++) begin
      z = longint'(s.cam_pos) + longint'(i * len) - longint'(off);
      s.wrapped = 1'b0;
      if (trk_len != 0 && z >= longint'(trk_len)) begin
        z = z - longint'(trk_len);
        s.wrapped = 1'b1;
      end
      s.seg_z = z[23:0];
      s.frame_start = (i == 0);
      y_acc = y_acc + int'($urandom_range(0, 400)) - 200;
      x_acc = x_acc + int'($urandom_range(0, 100)) - 50;
      s.seg_x = 17'(x_acc);
      s.seg_y = 17'(y_acc);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 5))
          0: bend = 32767;
          1: bend = -32768;
          2, 3: bend = 0;
          default: bend = $urandom_range(0, 1024) - 512;
        endcase
      end
      s.seg_curve = 16'(bend);
      s.seg_index = 16'(idx0 + i);
      if ($urandom_range(0, 99) < 4) begin
        s.wrapped = ~s.wrapped;
        s.seg_z = 24'($urandom);
      end
      drive_segment(s, 1'b0, '0);
      after_transfer();
    end
  endtask

  // Segments with every field random.
  task automatic send_noise(int n);
    segment_t s;
    repeat (n) begin
      s = mk_seg(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
      drive_segment(s, 1'b0, '0);
      after_transfer();
    end
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Compare each result transfer with the oldest pending projection.
  always @(posedge clk_i) begin : result_check
    projection_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.screen_x = m_axis_tdata_o[15:0];
      got.screen_y = m_axis_tdata_o[31:16];
      got.half_width_px = m_axis_tdata_o[47:32];
      got.clip_y = m_axis_tdata_o[63:48];
      got.prev_x = m_axis_tdata_o[79:64];
      got.prev_y = m_axis_tdata_o[95:80];
      got.prev_w = m_axis_tdata_o[111:96];
      got.visible = m_axis_tuser_o[0];
      got.behind_camera = m_axis_tuser_o[1];
      got.stripe = m_axis_tuser_o[2];
      if (pending_proj.size() == 0) begin
        $error("result transfer with no projection pending");
        n_errors++;
      end else begin
        want = pending_proj.pop_front();
        check_field("screen_x", want.screen_x, got.screen_x);
        check_field("screen_y", want.screen_y, got.screen_y);
        check_field("half_width_px", want.half_width_px, got.half_width_px);
        check_field("clip_y", want.clip_y, got.clip_y);
        check_field("prev_x", want.prev_x, got.prev_x);
        check_field("prev_y", want.prev_y, got.prev_y);
        check_field("prev_w", want.prev_w, got.prev_w);
        check_field("visible", want.visible, got.visible);
        check_field("behind_camera", want.behind_camera, got.behind_camera);
        check_field("stripe", want.stripe, got.stripe);
      end
      n_visible += got.visible;
      n_behind += got.behind_camera;
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin : receiver
    ready_mode_e mode;
    int          mode_left, hold_left;
    mode = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: m_axis_tready_i <= 1'b1;
          READY_HALF:   m_axis_tready_i <= 1'($urandom_range(0, 1));
          default:      m_axis_tready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Stimulus: directed table, then random phases under changing settings.
  initial begin : stimulus
    bit prev_reg, hold_done, pause_done;
    int phase_start;

    // Defaults after reset.
    add_row(typed_row(seg_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                      320, 240, 0, 480, 0, 0, 0, 0, 1, 0));
    add_row(seg_row(0, 0, 0, 0, 1000, 0, 0, 256, 0, 3));
    add_row(seg_row(0, 0, 1048575, 65535, 2000, 65535, -65536, 32767, 0, 65535));
    add_row(seg_row(0, 16777215, -1048576, -65536, 0, -65536, 65535, -32768, 0, 1));
    add_row(seg_row(0, 0, 0, 0, 1, 65535, 65535, 32767, 0, 2));
    add_row(seg_row(0, 1000, 0, 0, 16777215, -65536, -65536, 32767, 1, 4));
    add_row(seg_row(0, 0, -1000, 0, 3000, 0, 0, 32767, 0, 6));
    add_row(seg_row(0, 0, 0, 0, 4000, 0, -1500, -32768, 0, 7));
    add_row(seg_row(1, 0, 0, 0, 500, 0, 0, 0, 0, 8));
    add_row(seg_row(0, 0, 0, 0, 400, 0, 0, 0, 0, 9));
    // Zero camera depth: scale is zero but the segment is in front.
    add_row(reg_row(REG_CAMERA_DEPTH, 0));
    add_row(seg_row(1, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(typed_row(seg_row(0, 0, 0, 0, 100, 0, 0, 0, 0, 5),
                      320, 240, 0, 480, 320, 240, 0, 1, 0, 1));
    // Zero screen size.
    add_row(reg_row(REG_SCREEN_WIDTH, 0));
    add_row(reg_row(REG_SCREEN_HEIGHT, 0));
    add_row(seg_row(1, 10, 0, 0, 3, 0, 0, 0, 0, 0));
    add_row(typed_row(seg_row(0, 100, 0, 0, 100, 0, 0, 0, 0, 65535),
                      0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    // Every register at its maximum; writes past the list are ignored.
    add_row(reg_row(REG_CAMERA_DEPTH, 65535));
    add_row(reg_row(REG_CAMERA_HEIGHT, 65535));
    add_row(reg_row(REG_ROAD_HALF_WIDTH, 65535));
    add_row(reg_row(REG_SCREEN_WIDTH, 4095));
    add_row(reg_row(REG_SCREEN_HEIGHT, 4095));
    add_row(reg_row(REG_TRACK_LENGTH, 16777215));
    add_row(reg_row(REG_SPARE_LO, 16777215));
    add_row(reg_row(REG_SPARE_HI, 5921370));
    add_row(seg_row(1, 0, -1048576, -65536, 16777215, 65535, -65536, 32767, 1, 65534));
    add_row(seg_row(0, 16777215, 1048575, 65535, 0, -65536, 65535, 32767, 1, 3));
    add_row(seg_row(0, 0, 0, 0, 1, 0, 0, 32767, 0, 10));
    add_row(seg_row(0, 100, 0, 0, 50, 0, 0, 0, 1, 11));
    // Every register at its minimum, but camera depth and screen size at one.
    add_row(reg_row(REG_CAMERA_DEPTH, 1));
    add_row(reg_row(REG_CAMERA_HEIGHT, 0));
    add_row(reg_row(REG_ROAD_HALF_WIDTH, 0));
    add_row(reg_row(REG_SCREEN_WIDTH, 1));
    add_row(reg_row(REG_SCREEN_HEIGHT, 1));
    add_row(reg_row(REG_TRACK_LENGTH, 0));
    add_row(seg_row(1, 0, 0, 0, 1, 1, 0, 0, 0, 12));
    add_row(seg_row(0, 0, 5, 0, 2, -1, -1, 0, 0, 13));

    prev_reg = 1'b0;
    hold_done = 1'b0;
    pause_done = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!prev_reg) begin
          wait_drained();
        end
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) begin
          cfg_we_i <= 1'b0;
          n_settings++;
        end
        drive_segment(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].want);
        after_transfer();
        prev_reg = 1'b0;
      end
    end

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      apply_phase_settings(ph);
      phase_start = n_sent;
      while (n_sent < phase_start + RANDOM_ITEMS / N_PHASES) begin
        if (ph == 3 && !hold_done) begin
          // Long receiver hold-off while the sender keeps offering.
          hold_req = 1'b1;
          no_gap_left = 40;
          hold_done = 1'b1;
        end
        if (ph == 5 && !pause_done && n_sent >= phase_start + 40) begin
          wait_drained();
          pause_done = 1'b1;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_frame($urandom_range(3, 40));
        end else begin
          send_noise($urandom_range(1, 6));
        end
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Projected %0d segments in %0d frames under %0d register settings.",
             n_sent, n_frames, n_settings);
    $display("Of these %0d were drawn and %0d lay behind the camera.", n_visible, n_behind);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
